### rtl/core/tzo_pkg.sv
// ----------------------------------------------------------------------------
// tzo_pkg
// Types, register codes and calendar helpers for the time-zone offset block.
// ----------------------------------------------------------------------------
package tzo_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_DIRECTION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_HOURS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_MINUTES   = 2'd2;

  // Offset direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_EAST = 2'd1;
  localparam logic [1:0] DIR_WEST = 2'd2;

  localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
  localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
  localparam logic [4:0] LEAP_FEB_DAYS    = 5'd29;
  localparam logic [3:0] MONTH_FEB        = 4'd2;
  localparam logic [3:0] MONTH_DEC        = 4'd12;
  localparam logic [3:0] MONTH_JAN        = 4'd1;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
  localparam int            RECIP_W     = 13;
  localparam int            RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam logic [YEAR_W-1:0]  CENTURY   = 14'd100;

  // Month lengths; codes outside 1..12 count as 31 days
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } utc_time_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   local_year;
    logic [MONTH_W-1:0]  local_month;
    logic [DAY_W-1:0]    local_day;
    logic [HOUR_W-1:0]   local_hour;
    logic [MINUTE_W-1:0] local_minute;
    logic [SECOND_W-1:0] local_second;
  } local_time_t;

  typedef struct packed {
    logic [1:0] direction;
    logic [3:0] hours;
    logic [5:0] minutes;
  } tzo_cfg_t;

  // Gregorian leap year: divisible by 4 and not by 100, or by 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W+RECIP_W-1:0] prod;
    logic [YEAR_W+RECIP_W-RECIP_SHIFT-1:0] q;
    logic [YEAR_W-1:0] hund;
    logic [YEAR_W-1:0] rem;
    logic cent;
    prod = {{RECIP_W{1'b0}}, y} * {{YEAR_W{1'b0}}, RECIP_100};
    q    = prod[YEAR_W+RECIP_W-1:RECIP_SHIFT];
    hund = YEAR_W'({{(YEAR_W-$bits(q)){1'b0}}, q} * CENTURY);
    rem  = y - hund;
    cent = (rem == '0);
    return ((y[1:0] == 2'b00) && !cent) || (cent && (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m,
                                            input logic leap);
    if ((m == MONTH_FEB) && leap) begin
      return LEAP_FEB_DAYS;
    end
    return MONTH_LEN[m];
  endfunction

endpackage

### rtl/core/tzo_stream_if.sv
// ----------------------------------------------------------------------------
// tzo_stream_if
// Valid/ready stream carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface tzo_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tzo_cfg.sv
// ----------------------------------------------------------------------------
// tzo_cfg
// Offset configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module tzo_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [tzo_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tzo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tzo_pkg::tzo_cfg_t                cfg
);
  import tzo_pkg::*;

  tzo_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_OFFSET_DIRECTION: begin
          regs.direction <= cfg_wdata[1:0];
        end
        REG_OFFSET_HOURS: begin
          regs.hours <= cfg_wdata[3:0];
        end
        REG_OFFSET_MINUTES: begin
          regs.minutes <= cfg_wdata;
        end
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

### rtl/core/tzo_calc.sv
// ----------------------------------------------------------------------------
// tzo_calc
// Applies the offset to one date-time with minute, hour, day, month and
// year carry or borrow.
// ----------------------------------------------------------------------------
module tzo_calc (
  input  tzo_pkg::utc_time_t   utc_q,
  input  tzo_pkg::tzo_cfg_t    cfg,
  output tzo_pkg::local_time_t result
);
  import tzo_pkg::*;

  logic       leap;

  // east
  logic [6:0] a_min_sum;
  logic       a_min_carry;
  logic [4:0] a_oh;
  logic [5:0] a_hr_sum;
  logic       a_hr_carry;
  logic [5:0] a_day;
  logic       a_day_over;
  logic [4:0] a_mon;
  logic       a_year_carry;
  local_time_t a_res;

  // west / none
  logic [5:0] s_om;
  logic [3:0] s_ohr;
  logic       s_min_borrow;
  logic [6:0] s_min_wrap;
  logic [4:0] s_oh;
  logic       s_hr_borrow;
  logic [5:0] s_hr_wrap;
  logic [4:0] s_day;
  logic [3:0] s_mon_dec;
  local_time_t s_res;

  assign leap = is_leap(utc_q.year);

  always_comb begin
    a_min_sum   = {1'b0, utc_q.minute} + {1'b0, cfg.minutes};
    a_min_carry = (a_min_sum >= MINUTES_PER_HOUR);
    a_oh        = {1'b0, cfg.hours} + {4'b0, a_min_carry};
    a_hr_sum    = {1'b0, utc_q.hour} + {1'b0, a_oh};
    a_hr_carry  = (a_hr_sum >= HOURS_PER_DAY);
    a_day       = {1'b0, utc_q.day} + {5'b0, a_hr_carry};
    a_day_over  = (a_day > {1'b0, month_days(utc_q.month, leap)});
    a_mon       = {1'b0, utc_q.month} + {4'b0, a_day_over};
    a_year_carry = (a_mon > {1'b0, MONTH_DEC});

    a_res.local_minute = a_min_carry ? 6'(a_min_sum - MINUTES_PER_HOUR) : a_min_sum[5:0];
    a_res.local_hour   = a_hr_carry ? 5'(a_hr_sum - HOURS_PER_DAY) : a_hr_sum[4:0];
    a_res.local_day    = a_day_over ? 5'd1 : a_day[4:0];
    a_res.local_month  = a_year_carry ? MONTH_JAN : a_mon[3:0];
    a_res.local_year   = a_year_carry ? utc_q.year + 14'd1 : utc_q.year;
    a_res.local_second = utc_q.second;
  end

  always_comb begin
    // reserved direction acts as no offset
    s_om  = (cfg.direction == DIR_WEST) ? cfg.minutes : 6'd0;
    s_ohr = (cfg.direction == DIR_WEST) ? cfg.hours : 4'd0;

    s_min_borrow = (utc_q.minute < s_om);
    s_min_wrap   = {1'b0, utc_q.minute} + MINUTES_PER_HOUR - {1'b0, s_om};
    s_oh         = {1'b0, s_ohr} + {4'b0, s_min_borrow};
    s_hr_borrow  = (utc_q.hour < s_oh);
    s_hr_wrap    = {1'b0, utc_q.hour} + HOURS_PER_DAY - {1'b0, s_oh};
    s_day        = utc_q.day - {4'b0, s_hr_borrow};
    s_mon_dec    = utc_q.month - 4'd1;

    s_res.local_minute = s_min_borrow ? s_min_wrap[5:0] : utc_q.minute - s_om;
    s_res.local_hour   = s_hr_borrow ? s_hr_wrap[4:0] : utc_q.hour - s_oh;
    s_res.local_second = utc_q.second;
    s_res.local_year   = utc_q.year;
    s_res.local_month  = utc_q.month;
    s_res.local_day    = s_day;
    if (s_day == '0) begin
      // step back a month; a December wrap never lands on February, so
      // the leap flag of the input year is the one that counts
      if (s_mon_dec == '0) begin
        s_res.local_month = MONTH_DEC;
        s_res.local_year  = utc_q.year - 14'd1;
      end else begin
        s_res.local_month = s_mon_dec;
      end
      s_res.local_day = month_days(s_res.local_month, leap);
    end
  end

  assign result = (cfg.direction == DIR_EAST) ? a_res : s_res;

endmodule

### rtl/core/timezone_offset_date_adjust.sv
// ----------------------------------------------------------------------------
// timezone_offset_date_adjust
// UTC date-time to local date-time with a configured time-zone offset.
//
//   channel     role    payload
//   utc         sink    year, month, day, hour, minute, second
//   local_time  source  local_year .. local_second
//   cfg_*       write   offset_direction, offset_hours, offset_minutes
//
// One item per cycle sustained while local_time is ready; each accepted item
// passes through the input register, then the result register.
// The leap-year check (multiply by reciprocal of 100) sets the path length.
// Reset clears both valid flags and the offset registers to zero.
// A stalled result holds while the input register still takes one more item.
// ----------------------------------------------------------------------------
module timezone_offset_date_adjust (
  input  logic                             clk,
  input  logic                             rst,
  tzo_stream_if.sink                       utc,
  tzo_stream_if.source                     local_time,
  input  logic                             cfg_wen,
  input  logic [tzo_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tzo_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tzo_pkg::*;

  tzo_cfg_t    cfg;
  logic        stage_valid;
  utc_time_t   stage_data;
  logic        result_valid;
  local_time_t result_data;
  local_time_t calc_result;
  logic        take_out;
  logic        stage_ready;

  tzo_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tzo_calc u_calc (
    .utc_q  (stage_data),
    .cfg    (cfg),
    .result (calc_result)
  );

  assign take_out    = !result_valid || local_time.ready;
  assign stage_ready = !stage_valid || take_out;
  assign utc.ready   = stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (stage_ready) begin
        stage_valid <= utc.valid;
      end
      if (take_out) begin
        result_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (utc.valid && stage_ready) begin
      stage_data <= utc.data;
    end
    if (take_out && stage_valid) begin
      result_data <= calc_result;
    end
  end

  assign local_time.valid = result_valid;
  assign local_time.data  = result_data;

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (utc.valid && utc.ready) |=> stage_valid)
    else $error("accepted item not held in input register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !take_out) |=> (stage_valid && $stable(stage_data)))
    else $error("input register changed while result stalled");

  a_second_pass: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && take_out) |=>
      (local_time.valid && local_time.data.local_second == $past(stage_data.second)))
    else $error("second not passed through");

endmodule
